[hdl/rk4_drag_velocity_step_core_macros.svh]
// ----------------------------------------------------------------------------
// rk4_drag_velocity_step_core_macros.svh
// Concurrent assertion macros used by the controller of the RK4 velocity step core.
// ----------------------------------------------------------------------------
`ifndef RK4_DRAG_VELOCITY_STEP_CORE_MACROS_SVH
`define RK4_DRAG_VELOCITY_STEP_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RK4_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RK4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RK4_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RK4_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/rk4dv_pkg.sv]
// ----------------------------------------------------------------------------
// rk4dv_pkg
// Shared types and constants for the RK4 drag velocity step core.
// ----------------------------------------------------------------------------
package rk4dv_pkg;

    // divide-by-three unit: one hex digit per cycle over a 52-bit dividend
    localparam int unsigned DIV_STEPS = 13;
    localparam int unsigned DIV_CNT_W = 4;

    // shared multiplier operand selects
    localparam logic [1:0] MUL_SQ = 2'd0;  // |v| * |v|
    localparam logic [1:0] MUL_LO = 2'd1;  // low word of v^2 * k
    localparam logic [1:0] MUL_HI = 2'd2;  // high word of v^2 * k
    localparam logic [1:0] MUL_DT = 2'd3;  // a * dt

    // RK4 stage indexes
    localparam logic [1:0] STAGE_FIRST = 2'd0;
    localparam logic [1:0] STAGE_FULL  = 2'd2;  // k3: stage velocity uses full dt
    localparam logic [1:0] STAGE_LAST  = 2'd3;  // k4: no stage velocity

    typedef struct packed {
        logic       load;
        logic       start;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       sum_en;
        logic       clamp_en;
        logic       acc_en;
        logic [1:0] stage;
        logic       div_load;
        logic       div_en;
        logic       fin_en;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic finished;
    } t_dp_sts;

endpackage

[hdl/rk4dv_ctrl.sv]
// ----------------------------------------------------------------------------
// rk4dv_ctrl
// Sequencer for the RK4 step: four derivative evaluations on the shared
// multiplier, the divide by six, the state update and the output handshake.
// ----------------------------------------------------------------------------
`include "rk4_drag_velocity_step_core_macros.svh"

module rk4dv_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    input  logic               i_s_kind,
    output logic               o_s_ready,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    output rk4dv_pkg::t_dp_cmd o_cmd,
    input  rk4dv_pkg::t_dp_sts i_sts
);
    import rk4dv_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_LO    = 4'd2;
    localparam logic [3:0] S_HI    = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_CLAMP = 4'd5;
    localparam logic [3:0] S_MDT   = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_DLOAD = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [3:0]           r_state, n_state;
    logic [1:0]           r_stage, n_stage;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_div_done;
    logic                 w_acc_last;

    assign o_s_ready  = (r_state == S_IDLE);
    assign w_accept   = i_s_valid && o_s_ready;
    assign w_out_free = !r_out_valid || i_m_ready;
    assign o_m_valid  = r_out_valid;
    assign w_div_done = (r_state == S_DIV) && (r_div_cnt == DIV_LAST);
    assign w_acc_last = (r_state == S_ACC) && (r_stage == STAGE_LAST);

    always_comb begin
        o_cmd       = '0;
        o_cmd.stage = r_stage;
        n_state     = r_state;
        n_stage     = r_stage;
        n_div_cnt   = r_div_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load  = !i_s_kind;
                    o_cmd.start = i_s_kind;
                    n_stage     = STAGE_FIRST;
                    n_state     = (i_s_kind && !i_sts.finished) ? S_SQ : S_DONE;
                end
            end
            S_SQ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SQ;
                n_state       = S_LO;
            end
            S_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LO;
                n_state       = S_HI;
            end
            S_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_HI;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp_en = 1'b1;
                n_state        = S_MDT;
            end
            S_MDT: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DT;
                n_state       = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                if (w_acc_last) begin
                    n_state = S_DLOAD;
                end else begin
                    n_stage = r_stage + 2'd1;
                    n_state = S_SQ;
                end
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_div_cnt      = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_en = 1'b1;
                n_div_cnt    = r_div_cnt + 1'b1;
                if (w_div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin_en = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stage     <= STAGE_FIRST;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stage     <= n_stage;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `RK4_ASSERT_IMPLY(a_out_load_free, i_clk, i_rst_n, o_cmd.out_load, w_out_free)
    `RK4_ASSERT_NEXT(a_accept_branch, i_clk, i_rst_n, w_accept, r_state == S_SQ || r_state == S_DONE)
    `RK4_ASSERT_NEXT(a_div_exit, i_clk, i_rst_n, w_div_done, r_state == S_FIN)
    `RK4_ASSERT_NEXT(a_last_stage, i_clk, i_rst_n, w_acc_last, r_state == S_DLOAD)

endmodule

[hdl/rk4dv_dp.sv]
// ----------------------------------------------------------------------------
// rk4dv_dp
// Datapath: shared 32x32 multiplier, drag/gravity derivative, stage
// velocities, weighted sum, radix-16 divide by three, state and output regs.
// ----------------------------------------------------------------------------
module rk4dv_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rk4dv_pkg::t_dp_cmd i_cmd,
    output rk4dv_pkg::t_dp_sts o_sts,
    input  logic signed [31:0] i_start_velocity,
    input  logic [31:0]        i_start_time,
    input  logic [31:0]        i_drag_factor,
    input  logic [30:0]        i_gravity,
    input  logic [30:0]        i_time_step,
    input  logic [31:0]        i_time_limit,
    output logic [31:0]        o_time_now,
    output logic signed [31:0] o_velocity_now,
    output logic               o_finished,
    output logic               o_saturated
);
    import rk4dv_pkg::*;

    localparam logic signed [49:0] VMIN_50 = -50'sd2147483648;
    localparam logic signed [53:0] VMIN_54 = -54'sd2147483648;
    localparam logic [31:0]        VMIN_32 = 32'h8000_0000;
    localparam logic [48:0]        A_MAX   = 49'h0_8000_0000;

    logic signed [31:0] r_vel;
    logic [31:0]        r_time;
    logic signed [31:0] r_vs;
    logic [63:0]        r_prod;
    logic [31:0]        r_hi;
    logic [31:0]        r_lok;
    logic [47:0]        r_sum48;
    logic [31:0]        r_a;
    logic [65:0]        r_sum6;
    logic               r_sat;
    logic [51:0]        r_dv;
    logic [1:0]         r_rem;
    logic [31:0]        r_o_time;
    logic signed [31:0] r_o_vel;
    logic               r_o_fin;
    logic               r_o_sat;

    logic [31:0] w_mag, w_op_a, w_op_b;
    logic [63:0] w_prod, w_sum;
    logic [48:0] w_total;
    logic [65:0] w_weighted;
    logic [47:0] w_dec_stage;
    logic [49:0] w_vdiff;
    logic        w_vclip;
    logic [5:0]  w_x;
    logic [11:0] w_qp;
    logic [3:0]  w_q;
    logic [5:0]  w_r;
    logic [53:0] w_fdiff;
    logic        w_fclip;
    logic [32:0] w_tsum;
    logic        w_finished;

    assign w_mag = r_vs[31] ? 32'(-r_vs) : 32'(r_vs);

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SQ: begin
                w_op_a = w_mag;
                w_op_b = w_mag;
            end
            MUL_LO: begin
                w_op_a = r_prod[31:0];
                w_op_b = i_drag_factor;
            end
            MUL_HI: begin
                w_op_a = r_hi;
                w_op_b = i_drag_factor;
            end
            MUL_DT: begin
                w_op_a = r_a;
                w_op_b = {1'b0, i_time_step};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod  = 64'(w_op_a) * 64'(w_op_b);
    assign w_sum   = r_prod + {32'd0, r_lok};
    assign w_total = {1'b0, r_sum48} + {18'd0, i_gravity};

    // k1 and k4 weigh once, k2 and k3 twice
    assign w_weighted  = ((i_cmd.stage == STAGE_FIRST) || (i_cmd.stage == STAGE_LAST))
                       ? {2'b00, r_prod} : {1'b0, r_prod, 1'b0};
    assign w_dec_stage = (i_cmd.stage == STAGE_FULL) ? r_prod[63:16] : {1'b0, r_prod[63:17]};
    assign w_vdiff     = {{18{r_vel[31]}}, r_vel} - {2'b00, w_dec_stage};
    assign w_vclip     = $signed(w_vdiff) < VMIN_50;

    // one quotient digit: x < 48, floor(x/3) = (x*43) >> 7
    assign w_x  = {r_rem, r_dv[51:48]};
    assign w_qp = 12'(w_x) * 12'd43;
    assign w_q  = w_qp[10:7];
    assign w_r  = w_x - {1'b0, w_q, 1'b0} - {2'b00, w_q};

    assign w_fdiff = {{22{r_vel[31]}}, r_vel} - {2'b00, r_dv};
    assign w_fclip = $signed(w_fdiff) < VMIN_54;
    assign w_tsum  = {1'b0, r_time} + {2'b00, i_time_step};

    assign w_finished   = (r_time >= i_time_limit) || r_vel[31] || (r_vel == '0);
    assign o_sts.finished = w_finished;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel  <= '0;
            r_time <= '0;
        end else if (i_cmd.load) begin
            r_vel  <= i_start_velocity;
            r_time <= i_start_time;
        end else if (i_cmd.fin_en) begin
            r_vel  <= w_fclip ? VMIN_32 : w_fdiff[31:0];
            r_time <= w_tsum[32] ? 32'hFFFF_FFFF : w_tsum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.start) begin
            r_sat <= 1'b0;
        end else if (i_cmd.acc_en && (i_cmd.stage != STAGE_LAST)) begin
            r_sat <= r_sat | w_vclip;
        end else if (i_cmd.fin_en) begin
            r_sat <= r_sat | w_fclip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_vs <= r_vel;
        end else if (i_cmd.acc_en && (i_cmd.stage != STAGE_LAST)) begin
            r_vs <= w_vclip ? VMIN_32 : w_vdiff[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mul_en && (i_cmd.mul_sel == MUL_LO)) begin
            r_hi <= r_prod[63:32];
        end
        if (i_cmd.mul_en && (i_cmd.mul_sel == MUL_HI)) begin
            r_lok <= r_prod[63:32];
        end
        if (i_cmd.sum_en) begin
            r_sum48 <= w_sum[63:16];
        end
        if (i_cmd.clamp_en) begin
            r_a <= (w_total > A_MAX) ? VMIN_32 : w_total[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sum6 <= '0;
        end else if (i_cmd.acc_en) begin
            r_sum6 <= r_sum6 + w_weighted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dv  <= {3'b000, r_sum6[65:17]};
            r_rem <= 2'd0;
        end else if (i_cmd.div_en) begin
            r_dv  <= {r_dv[47:0], w_q};
            r_rem <= w_r[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_time <= r_time;
            r_o_vel  <= r_vel;
            r_o_fin  <= w_finished;
            r_o_sat  <= r_sat;
        end
    end

    assign o_time_now     = r_o_time;
    assign o_velocity_now = r_o_vel;
    assign o_finished     = r_o_fin;
    assign o_saturated    = r_o_sat;

endmodule

[hdl/rk4_drag_velocity_step_core.sv]
// Sequence: a load item, or a step once the run has finished, goes from acceptance to the
// done state; an active RK4 step first runs four derivatives and the final divide.
// An item is accepted only while idle; each active step makes sixteen passes through the
// one shared 32x32 multiplier (four per derivative), then the radix-16 divide by three.
// Reset: synchronous, active low; clears velocity, time and handshake state and
// returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// rk4_drag_velocity_step_core
// Top level: stream ports, APB configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
module rk4_drag_velocity_step_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] start_velocity, [63:32] start_time
    input  logic [0:0]  i_s_axis_tuser,   // [0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] time_now, [63:32] velocity_now
    output logic [1:0]  o_m_axis_tuser,   // [0] finished, [1] saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rk4dv_pkg::*;

    localparam logic [1:0] REG_DRAG    = 2'd0;
    localparam logic [1:0] REG_GRAVITY = 2'd1;
    localparam logic [1:0] REG_DT      = 2'd2;
    localparam logic [1:0] REG_LIMIT   = 2'd3;

    localparam logic [31:0] DRAG_RST    = 32'd1390571;
    localparam logic [30:0] GRAVITY_RST = 31'd642908;
    localparam logic [30:0] DT_RST      = 31'd6554;
    localparam logic [31:0] LIMIT_RST   = 32'd1638400;

    logic [31:0] r_drag_factor;
    logic [30:0] r_gravity;
    logic [30:0] r_time_step;
    logic [31:0] r_time_limit;
    logic        w_cfg_wr;
    logic [1:0]  w_cfg_idx;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    logic [31:0]        w_time_now;
    logic signed [31:0] w_velocity_now;
    logic               w_finished;
    logic               w_saturated;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drag_factor <= DRAG_RST;
            r_gravity     <= GRAVITY_RST;
            r_time_step   <= DT_RST;
            r_time_limit  <= LIMIT_RST;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_DRAG:    r_drag_factor <= pwdata;
                REG_GRAVITY: r_gravity     <= pwdata[30:0];
                REG_DT:      r_time_step   <= pwdata[30:0];
                REG_LIMIT:   r_time_limit  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_DRAG:    prdata = r_drag_factor;
            REG_GRAVITY: prdata = {1'b0, r_gravity};
            REG_DT:      prdata = {1'b0, r_time_step};
            REG_LIMIT:   prdata = r_time_limit;
            default:     prdata = '0;
        endcase
    end

    rk4dv_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_s_kind  (i_s_axis_tuser[0]),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_cmd     (w_cmd),
        .i_sts     (w_sts)
    );

    rk4dv_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_start_velocity (i_s_axis_tdata[31:0]),
        .i_start_time     (i_s_axis_tdata[63:32]),
        .i_drag_factor    (r_drag_factor),
        .i_gravity        (r_gravity),
        .i_time_step      (r_time_step),
        .i_time_limit     (r_time_limit),
        .o_time_now       (w_time_now),
        .o_velocity_now   (w_velocity_now),
        .o_finished       (w_finished),
        .o_saturated      (w_saturated)
    );

    assign o_m_axis_tdata = {w_velocity_now, w_time_now};
    assign o_m_axis_tuser = {w_saturated, w_finished};

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the RK4 drag velocity step core. A queue-fed driver offers
// load and step transactions, a predictor tracks velocity and time in Q16.16
// and the monitor compares every result transaction field by field.
// Configuration goes through the APB port while the core is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam logic [3:0] ADDR_DRAG  = 4'h0;
    localparam logic [3:0] ADDR_GRAV  = 4'h4;
    localparam logic [3:0] ADDR_DT    = 4'h8;
    localparam logic [3:0] ADDR_LIMIT = 4'hC;

    localparam logic [31:0] DRAG_RST  = 32'd1390571;
    localparam logic [31:0] GRAV_RST  = 32'd642908;
    localparam logic [31:0] DT_RST    = 32'd6554;
    localparam logic [31:0] LIMIT_RST = 32'd1638400;

    typedef struct packed {
        logic        kind;
        logic [31:0] vel;
        logic [31:0] tstart;
    } t_stim;

    typedef struct packed {
        logic [31:0] tnow;
        logic [31:0] vel;
        logic        fin;
        logic        sat;
    } t_rk4_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic        m_ready = 1'b0;
    logic [63:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_stim       cur_item = '0;
    logic        in_taken = 1'b0;
    logic        calm = 1'b0;
    logic        hold_on = 1'b0;
    int          err_count = 0;
    event        sink_hold_go;

    t_stim       item_queue[$];
    t_rk4_out    expected_states[$];

    // predictor state and configuration copy
    logic [31:0]        cfg_drag  = DRAG_RST;
    logic [31:0]        cfg_grav  = GRAV_RST;
    logic [31:0]        cfg_dt    = DT_RST;
    logic [31:0]        cfg_limit = LIMIT_RST;
    logic signed [31:0] vel_q = '0;
    logic [31:0]        time_q = '0;

    always #5 i_clk = ~i_clk;

    rk4_drag_velocity_step_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  ({cur_item.tstart, cur_item.vel}),  // [31:0] velocity, [63:32] time
        .i_s_axis_tuser  (cur_item.kind),                     // [0] kind
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [31:0] time_now, [63:32] velocity_now
        .o_m_axis_tuser  (o_m_axis_tuser),  // [0] finished, [1] saturated
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    task automatic flag_error(input string what, input logic [63:0] got,
                              input logic [63:0] want);
        $display("ERROR at %0t: %s got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic logic run_done();
        return (time_q >= cfg_limit) || (vel_q <= 0);
    endfunction

    // |dv/dt| in Q16.16, clamped to 2^31
    function automatic logic [63:0] drag_decel(input longint v);
        logic [63:0] mag, sq, hi_prod, lo_prod, total;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        sq = mag * mag;
        hi_prod = (sq >> 32) * 64'(cfg_drag);
        lo_prod = 64'(sq[31:0]) * 64'(cfg_drag);
        total = ((hi_prod + (lo_prod >> 32)) >> 16) + 64'(cfg_grav);
        if (total > 64'h8000_0000) total = 64'h8000_0000;
        return total;
    endfunction

    function automatic longint clip_vel(input longint x, inout logic hit);
        if (x < -64'sd2147483648) begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        if (x > 64'sd2147483647) begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        return x;
    endfunction

    function automatic t_rk4_out rk4_advance(input t_stim it);
        t_rk4_out    r;
        logic        hit;
        longint      v0, v1, v2, v3, vn;
        logic [63:0] dt, a1, a2, a3, a4, m1, m2, m3, m4, shi, slo, dec, tn;
        hit = 1'b0;
        if (it.kind == KIND_LOAD) begin
            vel_q = it.vel;
            time_q = it.tstart;
        end else if (!run_done()) begin
            dt = 64'(cfg_dt);
            v0 = longint'(vel_q);
            a1 = drag_decel(v0);
            v1 = clip_vel(v0 - longint'((a1 * dt) >> 17), hit);
            a2 = drag_decel(v1);
            v2 = clip_vel(v0 - longint'((a2 * dt) >> 17), hit);
            a3 = drag_decel(v2);
            v3 = clip_vel(v0 - longint'((a3 * dt) >> 16), hit);
            a4 = drag_decel(v3);
            m1 = a1 * dt;
            m2 = a2 * dt;
            m3 = a3 * dt;
            m4 = a4 * dt;
            shi = (m1 >> 16) + 2 * (m2 >> 16) + 2 * (m3 >> 16) + (m4 >> 16);
            slo = (m1 & 64'hFFFF) + 2 * (m2 & 64'hFFFF) + 2 * (m3 & 64'hFFFF)
                + (m4 & 64'hFFFF);
            dec = (shi + (slo >> 16)) / 6;
            vn = clip_vel(v0 - longint'(dec), hit);
            tn = 64'(time_q) + dt;
            vel_q = vn[31:0];
            time_q = (tn > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tn[31:0];
        end
        r.tnow = time_q;
        r.vel = vel_q;
        r.fin = run_done();
        r.sat = hit;
        return r;
    endfunction

    // input side
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && s_valid && o_s_axis_tready;
        if (i_rst_n && s_valid && o_s_axis_tready) begin
            expected_states.push_back(rk4_advance(cur_item));
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_valid || in_taken)) begin
            if (item_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
                cur_item <= item_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // output side
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            m_ready <= hold_on ? 1'b0 : (calm || $urandom_range(0, 99) >= 13);
        end
    end

    always begin
        @(sink_hold_go);
        hold_on = 1'b1;
        repeat (600) @(posedge i_clk);
        hold_on = 1'b0;
    end

    always @(posedge i_clk) begin : monitor
        t_rk4_out want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (expected_states.size() == 0) begin
                flag_error("unexpected transaction", o_m_axis_tdata, '0);
            end else begin
                want = expected_states.pop_front();
                if (o_m_axis_tdata[31:0] !== want.tnow)
                    flag_error("time_now", 64'(o_m_axis_tdata[31:0]), 64'(want.tnow));
                if (o_m_axis_tdata[63:32] !== want.vel)
                    flag_error("velocity_now", 64'(o_m_axis_tdata[63:32]), 64'(want.vel));
                if (o_m_axis_tuser[0] !== want.fin)
                    flag_error("finished", 64'(o_m_axis_tuser[0]), 64'(want.fin));
                if (o_m_axis_tuser[1] !== want.sat)
                    flag_error("saturated", 64'(o_m_axis_tuser[1]), 64'(want.sat));
            end
        end
    end

    task automatic check_reg(input logic [3:0] addr, input logic [31:0] want);
        logic [31:0] rd;
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b0;
        penable = 1'b0;
        paddr = addr;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if (rd !== want) flag_error("register readback", 64'(rd), 64'(want));
    endtask

    task automatic set_reg(input logic [3:0] addr, input logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr;
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (addr)
            ADDR_DRAG:  cfg_drag = val;
            ADDR_GRAV:  cfg_grav = val;
            ADDR_DT:    cfg_dt = val;
            ADDR_LIMIT: cfg_limit = val;
            default: ;
        endcase
        check_reg(addr, val);
    endtask

    task automatic set_config(input logic [31:0] drag, input logic [31:0] grav,
                              input logic [31:0] dt, input logic [31:0] limit);
        set_reg(ADDR_DRAG, drag);
        set_reg(ADDR_GRAV, grav);
        set_reg(ADDR_DT, dt);
        set_reg(ADDR_LIMIT, limit);
    endtask

    task automatic random_config();
        logic [31:0] drag, grav, dt, limit;
        case ($urandom_range(0, 3))
            0: drag = DRAG_RST;
            1: drag = $urandom_range(0, 1 << 24);
            2: drag = $urandom;
            default: drag = $urandom_range(0, 1 << 20);
        endcase
        case ($urandom_range(0, 3))
            0: grav = GRAV_RST;
            1: grav = $urandom_range(0, 40 << 16);
            2: grav = $urandom_range(0, 32'h7FFF_FFFF);
            default: grav = '0;
        endcase
        case ($urandom_range(0, 3))
            0: dt = DT_RST;
            1: dt = $urandom_range(1, 1 << 16);
            2: dt = $urandom_range(1, 32'h7FFF_FFFF);
            default: dt = $urandom_range(1, 655);
        endcase
        case ($urandom_range(0, 3))
            0: limit = LIMIT_RST;
            1: limit = $urandom_range(1 << 16, 1 << 26);
            2: limit = $urandom;
            default: limit = 32'hFFFF_FFFF;
        endcase
        set_config(drag, grav, dt, limit);
    endtask

    task automatic push_item(input logic kind, input logic [31:0] vel,
                             input logic [31:0] tstart);
        t_stim it;
        it.kind = kind;
        it.vel = vel;
        it.tstart = tstart;
        item_queue.push_back(it);
    endtask

    // load-then-step runs with random content, plus some loose noise
    task automatic queue_runs(input int n);
        int          pushed, steps;
        logic [31:0] v, t;
        pushed = 0;
        while (pushed < n) begin
            if ($urandom_range(0, 99) < 10) begin
                push_item(1'($urandom_range(0, 1)), $urandom, $urandom);
                pushed++;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: v = ($urandom_range(1, 3000) << 16)
                                        | $urandom_range(0, 16'hFFFF);
                    6: v = $urandom_range(1, 255);
                    7: v = $urandom;
                    8: v = 32'h7FFF_FFFF - $urandom_range(0, 1000);
                    default: v = -$urandom_range(0, 1000);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: t = (cfg_limit == 0) ? '0 : $urandom_range(0, cfg_limit - 1);
                    7, 8: t = '0;
                    default: t = $urandom;
                endcase
                push_item(KIND_LOAD, v, t);
                steps = $urandom_range(1, 40);
                repeat (steps) push_item(KIND_STEP, $urandom, $urandom);
                pushed += steps + 1;
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (item_queue.size() != 0 || s_valid || expected_states.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : main
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        check_reg(ADDR_DRAG, DRAG_RST);
        check_reg(ADDR_GRAV, GRAV_RST);
        check_reg(ADDR_DT, DT_RST);
        check_reg(ADDR_LIMIT, LIMIT_RST);

        @(posedge i_clk);
        push_item(KIND_STEP, '0, '0);
        push_item(KIND_LOAD, 32'd300 << 16, '0);
        repeat (3) push_item(KIND_STEP, $urandom, $urandom);
        push_item(KIND_LOAD, 32'h0000_0001, '0);
        push_item(KIND_STEP, '0, '0);
        push_item(KIND_LOAD, 32'd100 << 16, LIMIT_RST - 1);
        push_item(KIND_STEP, '0, '0);
        push_item(KIND_STEP, '0, '0);
        push_item(KIND_LOAD, 32'h8000_0000, 32'hFFFF_FFFF);
        push_item(KIND_STEP, '1, '1);
        push_item(KIND_LOAD, 32'h7FFF_FFFF, '0);
        push_item(KIND_STEP, '0, '0);
        wait_idle();

        set_config(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        @(posedge i_clk);
        push_item(KIND_LOAD, 32'd1000 << 16, 32'hFFFF_0000);
        push_item(KIND_STEP, '0, '0);
        push_item(KIND_STEP, '0, '0);
        push_item(KIND_LOAD, 32'h7FFF_FFFF, '0);
        push_item(KIND_STEP, '0, '0);
        wait_idle();

        set_config('0, '0, 32'd1, '0);
        @(posedge i_clk);
        push_item(KIND_LOAD, 32'd50 << 16, '0);
        push_item(KIND_STEP, '0, '0);
        wait_idle();

        set_reg(ADDR_LIMIT, 32'hFFFF_FFFF);
        @(posedge i_clk);
        push_item(KIND_LOAD, 32'd50 << 16, 32'd5);
        push_item(KIND_STEP, '0, '0);

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            if (p == 0) set_config(DRAG_RST, GRAV_RST, DT_RST, LIMIT_RST);
            else if (p == 1) set_config(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'hFFFF_FFFF);
            else random_config();
            @(posedge i_clk);
            calm = (p == 2);
            queue_runs(200);
            if (p == 4) -> sink_hold_go;
        end

        wait_idle();
        repeat (60) @(posedge i_clk);
        if (err_count == 0 && expected_states.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/rk4dv_pkg.sv
hdl/rk4dv_ctrl.sv
hdl/rk4dv_dp.sv
hdl/rk4_drag_velocity_step_core.sv
tb/tb.sv
